/* sv/sfd_pkg.sv */
package sfd_pkg;

  localparam int FRAME_BYTES   = 31;
  localparam int PAY_START     = 7;
  localparam int PAY_BYTES     = 20;
  localparam int SET1_WORDS    = 10;
  localparam int SET2_WORDS    = 9;
  localparam int QDEPTH        = 2;

  localparam logic [7:0] START_MARK = 8'h02;
  localparam logic [7:0] LEN_MARK   = 8'd31;
  localparam logic [7:0] END_MARK   = 8'h03;
  localparam logic [7:0] SET1_CODE  = 8'h01;

  localparam logic [3:0] SET1_LAST_IDX = 4'(SET1_WORDS - 1);
  localparam logic [3:0] SET2_LAST_IDX = 4'(SET2_WORDS - 1);

  localparam logic STATUS_WORD = 1'b0;
  localparam logic STATUS_CSUM = 1'b1;

  typedef logic [7:0] byte_t;

  // one decoded frame waiting for emission
  typedef struct packed {
    logic                       csum_err;
    logic                       set2;
    logic [PAY_BYTES-1:0][7:0]  payload;   // payload[j] is frame byte 7+j
  } frame_t;

  // queue status seen by the front and back ends
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

/* sv/sfd_if.sv */
interface sfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface sfd_out_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic        sensor_set;
  logic [3:0]  word_index;
  logic [15:0] word_value;
  logic        last;

  modport source (output valid, output status, output sensor_set, output word_index,
                  output word_value, output last, input ready);
  modport sink (input valid, input status, input sensor_set, input word_index,
                input word_value, input last, output ready);
endinterface

/* sv/sfd_front.sv */
module sfd_front (
  input  logic            clk,
  input  logic            rst_n,
  sfd_in_if.sink          in_ch,
  input  sfd_pkg::q_stat_t q_stat,
  output logic            push,
  output sfd_pkg::frame_t push_data
);

  sfd_pkg::byte_t win_r [sfd_pkg::FRAME_BYTES];
  sfd_pkg::byte_t win_nxt [sfd_pkg::FRAME_BYTES];
  logic [7:0]     sum_r;
  logic [7:0]     sum_nxt;
  logic [7:0]     sum_shift;
  logic [7:0]     csum;
  logic           acc;
  logic           framed;

  assign in_ch.ready = !q_stat.full;
  assign acc         = in_ch.valid && in_ch.ready;

  // running sum of all window bytes, updated per shift
  assign sum_shift = sum_r - win_r[0] + in_ch.rx_byte;
  // post-shift byte 2 is the pre-shift byte 3
  assign csum      = sum_shift - win_r[3];

  assign framed = (win_r[1] == sfd_pkg::START_MARK) && (win_r[2] == sfd_pkg::LEN_MARK)
                  && (in_ch.rx_byte == sfd_pkg::END_MARK);

  assign push = acc && framed;

  always_comb begin
    push_data.csum_err = (csum != win_r[3]);
    push_data.set2     = (win_r[5] != sfd_pkg::SET1_CODE);
    for (int j = 0; j < sfd_pkg::PAY_BYTES; j++) begin
      push_data.payload[j] = win_r[sfd_pkg::PAY_START + 1 + j];
    end
  end

  always_comb begin
    for (int i = 0; i < sfd_pkg::FRAME_BYTES; i++) begin
      win_nxt[i] = win_r[i];
    end
    sum_nxt = sum_r;
    if (acc) begin
      if (framed) begin
        for (int i = 0; i < sfd_pkg::FRAME_BYTES; i++) begin
          win_nxt[i] = '0;
        end
        sum_nxt = '0;
      end else begin
        for (int i = 0; i < sfd_pkg::FRAME_BYTES - 1; i++) begin
          win_nxt[i] = win_r[i + 1];
        end
        win_nxt[sfd_pkg::FRAME_BYTES - 1] = in_ch.rx_byte;
        sum_nxt = sum_shift;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < sfd_pkg::FRAME_BYTES; i++) begin
        win_r[i] <= '0;
      end
      sum_r <= '0;
    end else begin
      for (int i = 0; i < sfd_pkg::FRAME_BYTES; i++) begin
        win_r[i] <= win_nxt[i];
      end
      sum_r <= sum_nxt;
    end
  end

endmodule

/* sv/sfd_queue.sv */
module sfd_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  sfd_pkg::frame_t  push_data,
  input  logic             pop,
  output sfd_pkg::frame_t  head,
  output sfd_pkg::q_stat_t q_stat
);

  localparam int PW = $clog2(sfd_pkg::QDEPTH);

  sfd_pkg::frame_t mem_r [sfd_pkg::QDEPTH];
  logic [PW-1:0]   wr_ptr_r;
  logic [PW-1:0]   rd_ptr_r;
  logic [PW:0]     cnt_r;
  logic [PW:0]     cnt_nxt;

  assign q_stat.full  = (cnt_r == (PW+1)'(sfd_pkg::QDEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign head         = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(sfd_pkg::QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(sfd_pkg::QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

/* sv/sfd_back.sv */
module sfd_back (
  input  logic             clk,
  input  logic             rst_n,
  input  sfd_pkg::frame_t  head,
  input  sfd_pkg::q_stat_t q_stat,
  output logic             pop,
  sfd_out_if.source        out_ch
);

  logic [3:0]  idx_r;
  logic [3:0]  last_idx;
  logic        load;
  logic        is_last;
  logic        out_valid_r;
  logic        status_r;
  logic        set_r;
  logic [3:0]  index_r;
  logic [15:0] value_r;
  logic        last_r;

  assign load     = !q_stat.empty && (!out_valid_r || out_ch.ready);
  assign last_idx = head.set2 ? sfd_pkg::SET2_LAST_IDX : sfd_pkg::SET1_LAST_IDX;
  assign is_last  = head.csum_err || (idx_r == last_idx);
  assign pop      = load && is_last;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = status_r;
  assign out_ch.sensor_set = set_r;
  assign out_ch.word_index = index_r;
  assign out_ch.word_value = value_r;
  assign out_ch.last       = last_r;

  always_ff @(posedge clk) begin
    if (load) begin
      if (head.csum_err) begin
        status_r <= sfd_pkg::STATUS_CSUM;
        set_r    <= 1'b0;
        index_r  <= '0;
        value_r  <= '0;
      end else begin
        status_r <= sfd_pkg::STATUS_WORD;
        set_r    <= head.set2;
        index_r  <= idx_r;
        value_r  <= {head.payload[{idx_r, 1'b0}], head.payload[{idx_r, 1'b1}]};
      end
      last_r <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        idx_r       <= is_last ? '0 : idx_r + 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= sfd_pkg::SET1_LAST_IDX)
    else $error("word counter out of range");

  a_idx_needs_frame: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r != '0 |-> !q_stat.empty)
    else $error("word counter running without a queued frame");

  a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && status_r == sfd_pkg::STATUS_CSUM |-> last_r && value_r == '0)
    else $error("checksum error item not a lone last item");

  a_pop_clears_idx: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> idx_r == '0)
    else $error("word counter not cleared after frame done");

endmodule

/* sv/sensor_frame_deframer.sv */
// Serial sensor-frame receiver. One rx byte is accepted per cycle; in_ch.ready drops
// only while two decoded frames wait in the frame queue. A 31-byte frame closing
// with a valid checksum gives nine or ten 16-bit words, one item per cycle while the
// receiver is ready, the first via the frame queue and the output register; a bad
// checksum gives a single error item. The output register and two-entry frame queue
// let intake run on as words drain, so a ready receiver sustains one byte per cycle.
module sensor_frame_deframer (
  input  logic      clk,
  input  logic      rst_n,
  sfd_in_if.sink    in_ch,
  sfd_out_if.source out_ch
);

  logic             push;
  logic             pop;
  sfd_pkg::frame_t  push_data;
  sfd_pkg::frame_t  head;
  sfd_pkg::q_stat_t q_stat;

  sfd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  sfd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  sfd_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

/* bench/sfd_frame_check.sv */
`timescale 1ns / 1ps

module sfd_frame_check (
  input  logic clk,
  input  logic rst_n,
  sfd_in_if    in_ch,
  sfd_out_if   out_ch,
  output int   mismatches,
  output int   pending
);

  typedef struct packed {
    logic        status;
    logic        sensor_set;
    logic [3:0]  word_index;
    logic [15:0] word_value;
    logic        last;
  } sensor_word_t;

  sfd_pkg::byte_t rx_window [sfd_pkg::FRAME_BYTES];
  sensor_word_t   words_due [$];
  int             bad_words = 0;

  function automatic string word_str(input sensor_word_t w);
    return $sformatf("status=%0d set=%0d idx=%0d value=%h last=%0d",
                     w.status, w.sensor_set, w.word_index, w.word_value, w.last);
  endfunction

  task automatic report(input string what, input sensor_word_t want,
                        input sensor_word_t got);
    bad_words++;
    if (bad_words <= 10) begin
      $display("%0t %s: expected %s, got %s", $time, what, word_str(want), word_str(got));
    end
  endtask

  task automatic shift_in_byte(input sfd_pkg::byte_t b);
    sfd_pkg::byte_t sum;
    int             n_words;
    logic           set2;
    sensor_word_t   w;
    for (int i = 0; i < sfd_pkg::FRAME_BYTES - 1; i++) rx_window[i] = rx_window[i + 1];
    rx_window[sfd_pkg::FRAME_BYTES - 1] = b;
    if (rx_window[0] == sfd_pkg::START_MARK && rx_window[1] == sfd_pkg::LEN_MARK &&
        rx_window[sfd_pkg::FRAME_BYTES - 1] == sfd_pkg::END_MARK) begin
      sum = rx_window[0] + rx_window[1];
      for (int i = 3; i < sfd_pkg::FRAME_BYTES; i++) sum += rx_window[i];
      if (sum != rx_window[2]) begin
        w = '0;
        w.status = sfd_pkg::STATUS_CSUM;
        w.last = 1'b1;
        words_due.push_back(w);
      end else begin
        set2 = (rx_window[4] != sfd_pkg::SET1_CODE);
        n_words = set2 ? sfd_pkg::SET2_WORDS : sfd_pkg::SET1_WORDS;
        for (int k = 0; k < n_words; k++) begin
          w.status = sfd_pkg::STATUS_WORD;
          w.sensor_set = set2;
          w.word_index = 4'(k);
          w.word_value = {rx_window[sfd_pkg::PAY_START + 2 * k],
                          rx_window[sfd_pkg::PAY_START + 2 * k + 1]};
          w.last = (k == n_words - 1);
          words_due.push_back(w);
        end
      end
      foreach (rx_window[i]) rx_window[i] = '0;
    end
  endtask

  always @(posedge clk) begin
    sensor_word_t got;
    sensor_word_t want;
    if (!rst_n) begin
      foreach (rx_window[i]) rx_window[i] = '0;
      words_due.delete();
    end else begin
      if (in_ch.valid && in_ch.ready) shift_in_byte(in_ch.rx_byte);
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.status, out_ch.sensor_set, out_ch.word_index,
               out_ch.word_value, out_ch.last};
        if (words_due.size() == 0) begin
          report("unexpected item", '0, got);
        end else begin
          want = words_due.pop_front();
          if (got !== want) report("item mismatch", want, got);
        end
      end
    end
    mismatches <= bad_words;
    pending <= words_due.size();
  end

endmodule

/* bench/sensor_frame_deframer_tb.sv */
`timescale 1ns / 1ps

module sensor_frame_deframer_tb;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 400;
  localparam int RANDOM_BYTES = 100;

  typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES, FILL_RAMP} fill_t;

  logic           clk = 1'b0;
  logic           rst_n;
  int             word_mismatches;
  int             words_pending;
  int             cycle_count = 0;
  int             tx_idle_pct = 0;
  int             rx_stall_pct;
  logic           hold_req;
  sfd_pkg::byte_t frm [sfd_pkg::FRAME_BYTES];

  sfd_in_if  in_ch ();
  sfd_out_if out_ch ();

  sensor_frame_deframer uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  sfd_frame_check frame_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .mismatches (word_mismatches),
    .pending    (words_pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int hold_left;
    logic hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (hold_req && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  function automatic sfd_pkg::byte_t rand_byte();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom_range(255));
  endfunction

  function automatic sfd_pkg::byte_t noise_byte();
    case ($urandom_range(7))
      0: return sfd_pkg::START_MARK;
      1: return sfd_pkg::LEN_MARK;
      2: return sfd_pkg::END_MARK;
      default: return rand_byte();
    endcase
  endfunction

  function automatic sfd_pkg::byte_t rand_set_code();
    return ($urandom_range(1) != 0) ? sfd_pkg::SET1_CODE : rand_byte();
  endfunction

  task automatic build_frame(input sfd_pkg::byte_t set_code, input fill_t fill,
                             input bit bad_sum);
    sfd_pkg::byte_t sum;
    for (int i = 0; i < sfd_pkg::FRAME_BYTES; i++) begin
      case (fill)
        FILL_ZERO: frm[i] = 8'h00;
        FILL_ONES: frm[i] = 8'hFF;
        FILL_RAMP: frm[i] = 8'(i * 8 + 1);
        default:   frm[i] = rand_byte();
      endcase
    end
    frm[0] = sfd_pkg::START_MARK;
    frm[1] = sfd_pkg::LEN_MARK;
    frm[4] = set_code;
    frm[sfd_pkg::FRAME_BYTES - 1] = sfd_pkg::END_MARK;
    sum = frm[0] + frm[1];
    for (int i = 3; i < sfd_pkg::FRAME_BYTES; i++) sum += frm[i];
    frm[2] = bad_sum ? sum + 8'($urandom_range(1, 255)) : sum;
  endtask

  task automatic send_byte(input sfd_pkg::byte_t b);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_frame(input int n);
    for (int i = 0; i < n; i++) send_byte(frm[i]);
  endtask

  initial begin
    int sent;
    int good;
    int pick;
    int cut;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.rx_byte <= '0;
    hold_req <= 1'b0;
    rx_stall_pct <= 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    build_frame(sfd_pkg::SET1_CODE, FILL_ONES, 1'b0);
    send_frame(sfd_pkg::FRAME_BYTES);
    build_frame(8'hFF, FILL_RAMP, 1'b0);
    send_frame(sfd_pkg::FRAME_BYTES);
    build_frame(8'h00, FILL_ZERO, 1'b1);
    send_frame(sfd_pkg::FRAME_BYTES);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(sfd_pkg::START_MARK);
    send_byte(sfd_pkg::LEN_MARK);
    send_byte(sfd_pkg::END_MARK);

    for (int p = 0; p < 4; p++) begin
      tx_idle_pct = (p == 1) ? 48 : (p == 3) ? 25 : 0;
      rx_stall_pct <= (p == 2) ? 48 : (p == 3) ? 25 : 0;
      sent = 0;
      good = 0;
      if (p == 0) begin
        // two frames fill the queue while the receiver holds off
        hold_req <= 1'b1;
        repeat (2) begin
          build_frame(rand_set_code(), FILL_RANDOM, 1'b0);
          send_frame(sfd_pkg::FRAME_BYTES);
          sent += sfd_pkg::FRAME_BYTES;
          good++;
        end
      end
      while (sent < RANDOM_BYTES / 4 || good < 1) begin
        pick = $urandom_range(99);
        if (pick < 60) begin
          build_frame(rand_set_code(), FILL_RANDOM, 1'b0);
          send_frame(sfd_pkg::FRAME_BYTES);
          sent += sfd_pkg::FRAME_BYTES;
          good++;
        end else if (pick < 72) begin
          build_frame(rand_set_code(), FILL_RANDOM, 1'b1);
          send_frame(sfd_pkg::FRAME_BYTES);
          sent += sfd_pkg::FRAME_BYTES;
        end else if (pick < 84) begin
          cut = $urandom_range(1, 8);
          repeat (cut) send_byte(noise_byte());
          sent += cut;
        end else if (pick < 92) begin
          // frame cut short, next sequence follows directly
          build_frame(rand_set_code(), FILL_RANDOM, 1'b0);
          cut = $urandom_range(1, sfd_pkg::FRAME_BYTES - 1);
          send_frame(cut);
          sent += cut;
        end else begin
          build_frame(rand_set_code(), FILL_RANDOM, 1'b0);
          case ($urandom_range(2))
            0: frm[0] ^= 8'($urandom_range(1, 255));
            1: frm[1] ^= 8'($urandom_range(1, 255));
            default: frm[sfd_pkg::FRAME_BYTES - 1] ^= 8'($urandom_range(1, 255));
          endcase
          send_frame(sfd_pkg::FRAME_BYTES);
          sent += sfd_pkg::FRAME_BYTES;
        end
      end
    end

    in_ch.valid <= 1'b0;
    rx_stall_pct <= 0;
    do @(posedge clk); while (words_pending != 0);
    repeat (40) @(posedge clk);
    if (word_mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/sfd_pkg.sv
sv/sfd_if.sv
sv/sfd_front.sv
sv/sfd_queue.sv
sv/sfd_back.sv
sv/sensor_frame_deframer.sv
bench/sfd_frame_check.sv
bench/sensor_frame_deframer_tb.sv
